[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

[rtl/cmfg_pkg.sv]
// package for the cylinder facet generator: widths, register addresses, record types, cordic table
// no dependencies
package cmfg_pkg;
   localparam int MaxFacets = 64;
   localparam int CordicSteps = 14;
   localparam logic signed [17:0] CordicGain = 18'sd9949;
   localparam logic [2:0] RegAxisX = 3'd0;
   localparam logic [2:0] RegAxisY = 3'd1;
   localparam logic [2:0] RegAxisZ = 3'd2;
   localparam logic [2:0] RegHeight = 3'd3;
   localparam logic [2:0] RegRadius = 3'd4;
   localparam logic [2:0] RegCount = 3'd5;
   localparam logic [2:0] RegOpen = 3'd6;

   typedef struct packed {
      logic signed [15:0] ax, ay, az;
      logic [15:0] height, radius;
      logic [6:0] count;
      logic open_ends;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] r0x, r0y, r0z, r1x, r1y, r1z;
      logic [15:0] step;
   } basis_type;

   typedef struct packed {
      logic rec_kind;
      logic [7:0] vert_slot;
      logic signed [23:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [7:0] tri_first, tri_second, tri_third;
      logic last_of_run;
   } rec_type;

   function automatic logic signed [17:0] atan_val(input int i);
      case (i)
         0: atan_val = 18'sd8192;  1: atan_val = 18'sd4836;
         2: atan_val = 18'sd2555;  3: atan_val = 18'sd1297;
         4: atan_val = 18'sd651;   5: atan_val = 18'sd326;
         6: atan_val = 18'sd163;   7: atan_val = 18'sd81;
         8: atan_val = 18'sd41;    9: atan_val = 18'sd20;
         10: atan_val = 18'sd10;   11: atan_val = 18'sd5;
         12: atan_val = 18'sd3;    13: atan_val = 18'sd1;
         default: atan_val = 18'sd0;
      endcase
   endfunction

   function automatic logic signed [17:0] shr_tz(input logic signed [17:0] v, input int s);
      logic [17:0] m;
      begin
         m = v[17] ? 18'(-v) : v;
         m = m >> s;
         shr_tz = v[17] ? -$signed(m) : $signed(m);
      end
   endfunction

   // round half away from zero, arithmetic shift
   function automatic logic signed [47:0] rnd_sh(input logic signed [47:0] v, input int s);
      logic [47:0] m;
      begin
         m = v[47] ? 48'(-v) : v;
         m = (m + (48'd1 << (s - 1))) >> s;
         rnd_sh = v[47] ? -$signed(m) : $signed(m);
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) sat16 = 16'sh7fff;
      else if (v < -48'sd32768) sat16 = 16'sh8000;
      else sat16 = v[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) sat24 = 24'sh7fffff;
      else if (v < -48'sd8388608) sat24 = 24'sh800000;
      else sat24 = v[23:0];
   endfunction
endpackage

[rtl/cylinder_mesh_facet_generator.sv]
// cylinder facet generator top level
// req_ carries a facet number, rsp_ carries vertex and triangle records
// csr_ is a plain register write port, idle use only
// after a write or reset the basis unit recomputes the basis and step, and
// req_tready stays low until it has
// a facet passes a phase stage, a cordic with an input register and 14
// rotation stages, a radial multiply stage, a radial round stage and a
// position stage; reset clears all valid bits
// each facet then emits 4, 6 or 8 records, one per cycle while rsp_tready is
// high; the record sequencer sets the count
// facets at or above the effective count are accepted and dropped at the front
// the pipeline advances while the sequencer can take a facet or the position
// stage is empty, so a stall on rsp_ with it full halts all stages without loss
module cylinder_mesh_facet_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // facet_index[5:0]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // vert_slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tri_first..third
   output logic [151:0] rsp_tdata,
   output logic rsp_tuser,         // rec_kind
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [2:0] csr_addr,
   input  logic [15:0] csr_wdata
);
   import cmfg_pkg::*;
   cfg_type cfg_ff, cfg_in;
   basis_type bs;
   logic start_ff;
   logic bdone;
   logic en, ready_e;
   logic [6:0] n;
   logic v0_ff, v2_ff, vu_ff, v3_ff, cv;
   logic [5:0] f0_ff;
   logic [15:0] phase0_ff;
   logic [5:0] fpipe_ff [CordicSteps+1];
   logic [5:0] f2_ff, fu_ff, f3_ff;
   logic signed [15:0] co, si;
   logic signed [47:0] pa_ff [3], pb_ff [3];
   logic signed [15:0] u_ff [3];
   logic signed [47:0] ah_ff [3];
   logic signed [23:0] top_ff [3], bot_ff [3];
   logic signed [15:0] u3_ff [3];
   logic signed [15:0] av [3];
   rec_type rec;
   logic [5:0] fidx;

   assign fidx = req_tdata[5:0];
   assign av[0] = cfg_ff.ax; assign av[1] = cfg_ff.ay; assign av[2] = cfg_ff.az;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            RegAxisX: cfg_in.ax = csr_wdata;
            RegAxisY: cfg_in.ay = csr_wdata;
            RegAxisZ: cfg_in.az = csr_wdata;
            RegHeight: cfg_in.height = csr_wdata;
            RegRadius: cfg_in.radius = csr_wdata;
            RegCount: cfg_in.count = csr_wdata[6:0];
            RegOpen: cfg_in.open_ends = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
      n = cfg_ff.count < 7'd3 ? 7'd3 :
          (cfg_ff.count > 7'(MaxFacets) ? 7'(MaxFacets) : cfg_ff.count);
   end

   // all stages move together when the position stage is empty or the sequencer can take its facet
   assign en = ready_e || !v3_ff;
   assign req_tready = en && bdone;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ax: 16'sd0, ay: 16'sd0, az: 16'sd16384, height: 16'd256,
                     radius: 16'd256, count: 7'd8, open_ends: 1'b0};
         start_ff <= 1'b1;
         v0_ff <= 1'b0; v2_ff <= 1'b0; vu_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         start_ff <= csr_we && csr_addr <= RegOpen;
         if (en) begin
            v0_ff <= req_tvalid && bdone && (7'(fidx) < n);
            v2_ff <= cv; vu_ff <= v2_ff; v3_ff <= vu_ff;
         end
      end
      if (en) begin
         f0_ff <= fidx;
         phase0_ff <= 16'(fidx * bs.step);
         fpipe_ff[0] <= f0_ff;
         for (int i = 0; i < CordicSteps; i++) fpipe_ff[i+1] <= fpipe_ff[i];
         f2_ff <= fpipe_ff[CordicSteps]; fu_ff <= f2_ff; f3_ff <= fu_ff;
         pa_ff[0] <= 48'(co) * 48'(bs.r0x); pb_ff[0] <= 48'(si) * 48'(bs.r1x);
         pa_ff[1] <= 48'(co) * 48'(bs.r0y); pb_ff[1] <= 48'(si) * 48'(bs.r1y);
         pa_ff[2] <= 48'(co) * 48'(bs.r0z); pb_ff[2] <= 48'(si) * 48'(bs.r1z);
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= sat16(rnd_sh(pa_ff[i] + pb_ff[i], 14));
            ah_ff[i] <= 48'(av[i]) * 48'($signed({1'b0, cfg_ff.height}));
            u3_ff[i] <= u_ff[i];
            top_ff[i] <= sat24(rnd_sh(ah_ff[i], 15) + rnd_sh(48'($signed({1'b0, cfg_ff.radius}))
                        * 48'(u_ff[i]), 14));
            bot_ff[i] <= sat24(rnd_sh(ah_ff[i], 15) + rnd_sh(48'($signed({1'b0, cfg_ff.radius}))
                        * 48'(u_ff[i]), 14) - rnd_sh(ah_ff[i], 14));
         end
      end
   end

   cmfg_basis u_basis (.clock, .reset, .start(start_ff), .cfg(cfg_ff), .basis(bs),
      .done(bdone));

   cmfg_cordic u_cordic (.clock, .reset, .en, .vin(v0_ff), .phase(phase0_ff),
      .vout(cv), .co, .si);

   cmfg_emit u_emit (.clock, .reset, .in_valid(v3_ff), .in_ready(ready_e), .in_f(f3_ff),
      .in_top(top_ff), .in_bot(bot_ff), .in_u(u3_ff), .cfg(cfg_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rec(rec));

   assign rsp_tuser = rec.rec_kind;
   assign rsp_tlast = rec.last_of_run;
   assign rsp_tdata = {rec.tri_third, rec.tri_second, rec.tri_first,
      rec.norm_z, rec.norm_y, rec.norm_x, rec.pos_z, rec.pos_y, rec.pos_x, rec.vert_slot};
endmodule

[rtl/cmfg_basis.sv]
// sequential basis and angle step unit, restarted after reset and after each write to addresses 0 to 6
// depends on cmfg_pkg
module cmfg_basis (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  cmfg_pkg::cfg_type cfg,
   output cmfg_pkg::basis_type basis,
   output logic done
);
   import cmfg_pkg::*;
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SQRT = 6'b000010, S_DIV = 6'b000100,
      S_CROSS = 6'b001000, S_STEP = 6'b010000, S_DONE = 6'b100000
   } st_type;
   st_type st_ff, st_in;
   logic signed [16:0] c_ff [3], c_in [3];
   logic [33:0] rem_ff, rem_in;
   logic [33:0] res_ff, res_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] ci_ff, ci_in;
   logic [47:0] num_ff, num_in;
   logic [47:0] q_ff, q_in;
   logic [16:0] len_ff, len_in;
   basis_type b_ff, b_in;
   logic [6:0] n;
   logic [16:0] mag;
   logic [33:0] trial;
   logic [47:0] tnum;
   logic signed [47:0] qv, crs;
   logic [17:0] cnum;

   always_comb begin
      n = cfg.count < 7'd3 ? 7'd3 : (cfg.count > 7'(MaxFacets) ? 7'(MaxFacets) : cfg.count);
      st_in = st_ff; c_in = c_ff; rem_in = rem_ff; res_in = res_ff; cnt_in = cnt_ff;
      ci_in = ci_ff; num_in = num_ff; q_in = q_ff; len_in = len_ff; b_in = b_ff;
      mag = '0; trial = '0; tnum = '0; qv = '0; crs = '0; cnum = '0;
      case (st_ff)
         S_IDLE: begin
            if (cfg.ay < 16'sd1428) begin
               c_in[0] = 17'(cfg.az); c_in[1] = '0; c_in[2] = -17'(cfg.ax);
            end else begin
               c_in[0] = '0; c_in[1] = -17'(cfg.az); c_in[2] = 17'(cfg.ay);
            end
            rem_in = 34'(c_in[0]) * 34'(c_in[0]) + 34'(c_in[1]) * 34'(c_in[1])
                   + 34'(c_in[2]) * 34'(c_in[2]);
            res_in = '0; cnt_in = 6'd17; st_in = S_SQRT;
         end
         S_SQRT: begin
            // one bit pair a cycle
            trial = res_ff + (34'd1 << (2 * (cnt_ff - 6'd1)));
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + (34'd1 << (2 * (cnt_ff - 6'd1)));
            end else res_in = res_ff >> 1;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               st_in = S_DIV; ci_in = '0; cnt_in = 6'd48;
               len_in = res_in[16:0];
               mag = c_ff[0][16] ? 17'(-c_ff[0]) : 17'(c_ff[0]);
               num_in = 48'(mag) * 48'd16384 + 48'(res_in[16:1]);
               q_in = '0; rem_in = '0;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            tnum = 48'({rem_ff[32:0], num_ff[47]});
            num_in = num_ff << 1;
            if (len_ff != 0 && tnum >= 48'(len_ff)) begin
               rem_in = 34'(tnum - 48'(len_ff)); q_in = {q_ff[46:0], 1'b1};
            end else begin
               rem_in = tnum[33:0]; q_in = {q_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               qv = (len_ff == 0) ? 48'sd0 : (c_ff[ci_ff][16] ? -$signed(q_in) : $signed(q_in));
               case (ci_ff)
                  2'd0: b_in.r0x = sat16(qv);
                  2'd1: b_in.r0y = sat16(qv);
                  default: b_in.r0z = sat16(qv);
               endcase
               if (ci_ff == 2'd2) st_in = S_CROSS;
               else begin
                  ci_in = ci_ff + 2'd1; cnt_in = 6'd48; q_in = '0; rem_in = '0;
                  mag = c_ff[ci_in][16] ? 17'(-c_ff[ci_in]) : 17'(c_ff[ci_in]);
                  num_in = 48'(mag) * 48'd16384 + 48'(len_ff[16:1]);
               end
            end
         end
         S_CROSS: begin
            crs = 48'(cfg.ay) * 48'(b_ff.r0z) - 48'(cfg.az) * 48'(b_ff.r0y);
            b_in.r1x = sat16(rnd_sh(crs, 14));
            crs = 48'(cfg.az) * 48'(b_ff.r0x) - 48'(cfg.ax) * 48'(b_ff.r0z);
            b_in.r1y = sat16(rnd_sh(crs, 14));
            crs = 48'(cfg.ax) * 48'(b_ff.r0y) - 48'(cfg.ay) * 48'(b_ff.r0x);
            b_in.r1z = sat16(rnd_sh(crs, 14));
            num_in = 48'd65536 + 48'(n[6:1]); q_in = '0; rem_in = '0; cnt_in = 6'd18;
            st_in = S_STEP;
         end
         S_STEP: begin
            cnum = {rem_ff[16:0], num_ff[17]};
            num_in = num_ff << 1;
            if (cnum >= 18'(n)) begin
               rem_in = 34'(cnum - 18'(n)); q_in = {q_ff[46:0], 1'b1};
            end else begin
               rem_in = 34'(cnum); q_in = {q_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               b_in.step = q_in[15:0]; st_in = S_DONE;
            end
         end
         S_DONE: st_in = S_DONE;
         default: st_in = S_IDLE;
      endcase
      if (start) st_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
      c_ff <= c_in; rem_ff <= rem_in; res_ff <= res_in; cnt_ff <= cnt_in; ci_ff <= ci_in;
      num_ff <= num_in; q_ff <= q_in; len_ff <= len_in; b_ff <= b_in;
   end

   assign basis = b_ff;
   assign done = (st_ff == S_DONE) && !start;
endmodule

[rtl/cmfg_cordic.sv]
// pipelined cordic: an input register, then one rotation per stage
// depends on cmfg_pkg
module cmfg_cordic (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic vin,
   input  logic [15:0] phase,
   output logic vout,
   output logic signed [15:0] co,
   output logic signed [15:0] si
);
   import cmfg_pkg::*;
   localparam int Ns = CordicSteps;
   logic signed [17:0] x_ff [Ns+1], y_ff [Ns+1], z_ff [Ns+1];
   logic flip_ff [Ns+1];
   logic v_ff [Ns+1];
   logic signed [17:0] z0, xs, ys;

   always_comb begin
      z0 = 18'($signed(phase));
      if (z0 > 18'sd16384) z0 = z0 - 18'sd32768;
      else if (z0 < -18'sd16384) z0 = z0 + 18'sd32768;
      xs = flip_ff[Ns] ? -x_ff[Ns] : x_ff[Ns];
      ys = flip_ff[Ns] ? -y_ff[Ns] : y_ff[Ns];
      co = xs > 18'sd16384 ? 16'sd16384 : (xs < -18'sd16384 ? -16'sd16384 : xs[15:0]);
      si = ys > 18'sd16384 ? 16'sd16384 : (ys < -18'sd16384 ? -16'sd16384 : ys[15:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= Ns; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= vin;
         for (int i = 0; i < Ns; i++) v_ff[i+1] <= v_ff[i];
      end
      if (en) begin
         x_ff[0] <= CordicGain; y_ff[0] <= '0; z_ff[0] <= z0;
         flip_ff[0] <= ($signed(phase) > 16'sd16384) || ($signed(phase) < -16'sd16384);
         for (int i = 0; i < Ns; i++) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][17]) begin
               x_ff[i+1] <= x_ff[i] - shr_tz(y_ff[i], i);
               y_ff[i+1] <= y_ff[i] + shr_tz(x_ff[i], i);
               z_ff[i+1] <= z_ff[i] - atan_val(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + shr_tz(y_ff[i], i);
               y_ff[i+1] <= y_ff[i] - shr_tz(x_ff[i], i);
               z_ff[i+1] <= z_ff[i] + atan_val(i);
            end
         end
      end
   end

   assign vout = v_ff[Ns];
endmodule

[rtl/cmfg_emit.sv]
// record sequencer: holds one facet's geometry and emits its records in order
// depends on cmfg_pkg
module cmfg_emit (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [5:0] in_f,
   input  logic signed [23:0] in_top [3],
   input  logic signed [23:0] in_bot [3],
   input  logic signed [15:0] in_u [3],
   input  cmfg_pkg::cfg_type cfg,
   output logic out_valid,
   input  logic out_ready,
   output cmfg_pkg::rec_type out_rec
);
   import cmfg_pkg::*;
   logic busy_ff, busy_in;
   logic [2:0] k_ff, k_in;
   logic [5:0] f_ff;
   logic signed [23:0] top_ff [3], bot_ff [3];
   logic signed [15:0] u_ff [3];
   logic ov_ff, ov_in;
   rec_type rec_ff, rec_in;
   logic [7:0] n8, f8, nx8;
   logic [6:0] n;
   logic [2:0] nrec;
   logic fan, take, adv, lastk;
   logic [2:0] kk;

   always_comb begin
      n = cfg.count < 7'd3 ? 7'd3 : (cfg.count > 7'(MaxFacets) ? 7'(MaxFacets) : cfg.count);
      n8 = 8'(n); f8 = 8'(f_ff);
      nx8 = (f8 + 8'd1 == n8) ? 8'd0 : f8 + 8'd1;
      fan = !cfg.open_ends && f_ff != 6'd0 && (f8 + 8'd1 < n8);
      nrec = cfg.open_ends ? 3'd3 : (fan ? 3'd7 : 3'd5);
      adv = busy_ff && (!ov_ff || out_ready);
      lastk = k_ff == nrec;
      in_ready = !busy_ff || (adv && lastk);
      take = in_valid && in_ready;
      kk = cfg.open_ends && k_ff >= 3'd2 ? k_ff + 3'd2 : k_ff;
      rec_in = '0;
      case (kk)
         3'd0: begin rec_in.vert_slot = f8;
            rec_in.pos_x = top_ff[0]; rec_in.pos_y = top_ff[1]; rec_in.pos_z = top_ff[2];
            rec_in.norm_x = u_ff[0]; rec_in.norm_y = u_ff[1]; rec_in.norm_z = u_ff[2]; end
         3'd1: begin rec_in.vert_slot = f8 + n8;
            rec_in.pos_x = bot_ff[0]; rec_in.pos_y = bot_ff[1]; rec_in.pos_z = bot_ff[2];
            rec_in.norm_x = u_ff[0]; rec_in.norm_y = u_ff[1]; rec_in.norm_z = u_ff[2]; end
         3'd2: begin rec_in.vert_slot = f8 + 8'(2 * n);
            rec_in.pos_x = top_ff[0]; rec_in.pos_y = top_ff[1]; rec_in.pos_z = top_ff[2];
            rec_in.norm_x = cfg.ax; rec_in.norm_y = cfg.ay; rec_in.norm_z = cfg.az; end
         3'd3: begin rec_in.vert_slot = f8 + 8'(3 * n);
            rec_in.pos_x = bot_ff[0]; rec_in.pos_y = bot_ff[1]; rec_in.pos_z = bot_ff[2];
            rec_in.norm_x = sat16(-48'(cfg.ax)); rec_in.norm_y = sat16(-48'(cfg.ay));
            rec_in.norm_z = sat16(-48'(cfg.az)); end
         3'd4: begin rec_in.rec_kind = 1'b1;
            rec_in.tri_first = n8 + f8; rec_in.tri_second = n8 + nx8;
            rec_in.tri_third = nx8; end
         3'd5: begin rec_in.rec_kind = 1'b1;
            rec_in.tri_first = n8 + f8; rec_in.tri_second = nx8; rec_in.tri_third = f8; end
         3'd6: begin rec_in.rec_kind = 1'b1; rec_in.tri_first = 8'(2 * n);
            rec_in.tri_second = 8'(2 * n) + f8; rec_in.tri_third = 8'(2 * n) + f8 + 8'd1; end
         default: begin rec_in.rec_kind = 1'b1; rec_in.tri_first = 8'(3 * n);
            rec_in.tri_second = 8'(3 * n) + f8 + 8'd1; rec_in.tri_third = 8'(3 * n) + f8; end
      endcase
      rec_in.last_of_run = lastk;
      busy_in = busy_ff; k_in = k_ff;
      ov_in = ov_ff && !out_ready;
      if (adv) begin
         ov_in = 1'b1; k_in = k_ff + 3'd1;
         if (lastk) busy_in = 1'b0;
      end
      if (take) begin busy_in = 1'b1; k_in = '0; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; ov_ff <= 1'b0; k_ff <= '0;
      end else begin
         busy_ff <= busy_in; ov_ff <= ov_in; k_ff <= k_in;
      end
      if (adv) rec_ff <= rec_in;
      if (take) begin
         f_ff <= in_f; top_ff <= in_top; bot_ff <= in_bot; u_ff <= in_u;
      end
   end

   assign out_valid = ov_ff;
   assign out_rec = rec_ff;
endmodule

[rtl/cmfg_checker.sv]
// port-level checker for the cylinder facet generator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module cmfg_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tuser,
   input logic rsp_tlast,
   input logic [151:0] rsp_tdata
);
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CHK_IMPLY(a_last_tri, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   `CHK_IMPLY(a_tri_noslot, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[7:0] == 8'd0)
endmodule

bind cylinder_mesh_facet_generator cmfg_checker u_chk (.clock, .reset, .rsp_tvalid,
   .rsp_tready, .rsp_tuser, .rsp_tlast, .rsp_tdata);
